/* hdl/bsws_pkg.sv */
package bsws_pkg;

  localparam int SENSOR_COUNT_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 12;

  localparam int IDX_W     = 4;
  localparam int DIST_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SPEED_W   = 20;
  localparam int SUM_W     = 24;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SCALE = 2'd3;

  localparam logic [CFG_W-1:0] BASE_SPEED_RST  = 16'd8192;
  localparam logic [CFG_W-1:0] NEAR_LIMIT_RST  = 16'd819;
  localparam logic [CFG_W-1:0] FAR_LIMIT_RST   = 16'd2048;
  localparam logic [CFG_W-1:0] RANGE_SCALE_RST = 16'd13653;

  // sonars that carry a weight, in tenths
  localparam int WEIGHTED_SONARS = 8;
  localparam int LEFT_TENTHS  [WEIGHTED_SONARS] = '{2, 4, 6, 8, 10, 12, 14, 16};
  localparam int RIGHT_TENTHS [WEIGHTED_SONARS] = '{16, 14, 12, 10, 8, 6, 4, 2};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_STRENGTH,
    ST_WEIGHT,
    ST_ROUND,
    ST_ACCUM,
    ST_EMIT
  } state_t;

  // weight magnitude in fixed point, rounded to nearest; used on constants only
  function automatic int weight_mag(input int tenths, input int fb);
    return ((tenths << fb) + 5) / 10;
  endfunction

endpackage

/* hdl/bsws_ifs.sv */
interface bsws_in_if;
  import bsws_pkg::*;
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    sensor_index;
  logic                echo_valid;
  logic [DIST_W-1:0]   distance;

  modport source (output valid, sensor_index, echo_valid, distance, input ready);
  modport sink   (input valid, sensor_index, echo_valid, distance, output ready);
endinterface

interface bsws_out_if;
  import bsws_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;
  logic                      speed_saturated;

  modport source (output valid, left_speed, right_speed, speed_saturated, input ready);
  modport sink   (input valid, left_speed, right_speed, speed_saturated, output ready);
endinterface

interface bsws_cfg_if;
  import bsws_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/braitenberg_sonar_wheel_speed_core.sv */
// Braitenberg wheel speed core for a ring of sonars.
// sonar: one reading per request (sensor index, echo flag, distance in Q4.12 m).
// wheel: one request per scan, issued after the reading with the last index,
//   carrying the two saturated Q7.12 wheel speeds and a clip flag.
// cfg: register writes (base speed, near limit, far limit, range scale),
//   always ready; write only while no reading is in flight.
// Steps: a reading that sees an obstacle passes the range, strength, weight,
//   round and accumulate steps before the next reading can be taken. The
//   range and weight steps drive the two 2-bit-per-cycle serial multipliers,
//   W bits wide, W being the wider of 16 and FRACTION_BITS+1, first over
//   the range product and then over both weight products. A reading that
//   adds nothing goes straight to the accumulate step. The last reading of
//   a scan then loads the result register in the emit step.
// A finished result sits in the wheel register; further readings are still
//   taken while it waits, and only the next last-index reading holds until the
//   receiver takes the previous result.
// Reset clears both sums, drops wheel.valid and loads the default registers.
module braitenberg_sonar_wheel_speed_core #(
  parameter int SENSOR_COUNT  = bsws_pkg::SENSOR_COUNT_DEF,
  parameter int FRACTION_BITS = bsws_pkg::FRACTION_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  bsws_cfg_if.sink    cfg,
  bsws_in_if.sink     sonar,
  bsws_out_if.source  wheel
);
  import bsws_pkg::*;

  localparam int MW = (FRACTION_BITS + 1 > DIST_W) ? FRACTION_BITS + 1 : DIST_W;
  localparam int ND = (MW + 1) / 2;
  localparam int MP = 2 * ND;
  localparam int PW = MW + MP;
  localparam int CW = $clog2(ND);
  localparam int LAST_IDX = (SENSOR_COUNT - 1 > 15) ? 15 : SENSOR_COUNT - 1;
  localparam int WSEL_W = $clog2(WEIGHTED_SONARS);
  localparam logic [PW:0] ONE  = (PW + 1)'(1) << FRACTION_BITS;
  localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRACTION_BITS - 1);

  // one radix-4 step of a right-shifting multiplier
  function automatic logic [PW-1:0] mul_step(input logic [PW-1:0] p, input logic [MW-1:0] x);
    logic [MW+1:0] acc;
    acc = (MW + 2)'(p[PW-1:MP]) + (p[0] ? (MW + 2)'(x) : '0)
          + (p[1] ? {1'b0, x, 1'b0} : '0);
    return {acc, p[MP-1:2]};
  endfunction

  // subtract a contribution, clamp at the negative end
  function automatic logic [SUM_W-1:0] sum_sub(input logic [SUM_W-1:0] s,
                                               input logic [MW-1:0] amt);
    logic [SUM_W:0] d;
    d = {s[SUM_W-1], s} - (SUM_W + 1)'(amt);
    return (d[SUM_W] != d[SUM_W-1]) ? {1'b1, {(SUM_W - 1){1'b0}}} : d[SUM_W-1:0];
  endfunction

  // base + sum, clip to the speed range; msb of the result is the clip flag
  function automatic logic [SPEED_W:0] speed_of(input logic [CFG_W-1:0] base,
                                                 input logic [SUM_W-1:0] s);
    logic [SUM_W:0]         v;
    logic [SUM_W-SPEED_W+1:0] top;
    v = {{(SUM_W + 1 - CFG_W){base[CFG_W-1]}}, base} + {s[SUM_W-1], s};
    top = v[SUM_W:SPEED_W-1];
    if ((&top) || !(|top)) begin
      return {1'b0, v[SPEED_W-1:0]};
    end
    return {1'b1, v[SUM_W], {(SPEED_W - 1){~v[SUM_W]}}};
  endfunction

  state_t state, state_next;

  logic [CFG_W-1:0] base_speed, near_limit, far_limit, range_scale;
  logic [SUM_W-1:0] left_sum, right_sum;
  logic [PW-1:0]    pa, pb;
  logic [MW-1:0]    xa, xb;
  logic [MW-1:0]    left_amt, right_amt;
  logic [CW-1:0]    cnt;
  logic [WSEL_W-1:0] weight_sel;
  logic             last;
  logic             out_valid;
  logic signed [SPEED_W-1:0] out_left, out_right;
  logic             out_sat;

  logic             in_ready, range_step, strength_load, weight_step;
  logic             round_load, accum_en, emit_load;
  logic             accept, out_free, cnt_done;
  logic             in_range, contrib, is_last;
  logic [DIST_W-1:0] diff;
  logic [PW:0]      ra_shift, rb_shift;
  logic [MW-1:0]    strength;
  logic [SPEED_W:0] left_res, right_res;
  logic [MW-1:0]    weight_left  [WEIGHTED_SONARS];
  logic [MW-1:0]    weight_right [WEIGHTED_SONARS];

  for (genvar g = 0; g < WEIGHTED_SONARS; g++) begin : g_weight
    assign weight_left[g]  = MW'(weight_mag(LEFT_TENTHS[g], FRACTION_BITS));
    assign weight_right[g] = MW'(weight_mag(RIGHT_TENTHS[g], FRACTION_BITS));
  end

  assign accept   = sonar.valid && in_ready;
  assign out_free = !out_valid || wheel.ready;
  assign cnt_done = (cnt == CW'(ND - 1));

  assign in_range = (6'(sonar.sensor_index) < 6'(SENSOR_COUNT));
  assign is_last  = in_range && (sonar.sensor_index == IDX_W'(LAST_IDX));
  assign contrib  = in_range && sonar.echo_valid && (sonar.distance < far_limit)
                    && (sonar.sensor_index < IDX_W'(WEIGHTED_SONARS));
  assign diff     = (sonar.distance < near_limit) ? '0 : sonar.distance - near_limit;

  // rounded, scaled products
  assign ra_shift = ({1'b0, pa} + HALF) >> FRACTION_BITS;
  assign rb_shift = ({1'b0, pb} + HALF) >> FRACTION_BITS;
  assign strength = (ra_shift > ONE) ? '0 : MW'(ONE - ra_shift);

  assign left_res  = speed_of(base_speed, left_sum);
  assign right_res = speed_of(base_speed, right_sum);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = contrib ? ST_RANGE : ST_ACCUM;
        end
      end
      ST_RANGE: begin
        if (cnt_done) begin
          state_next = ST_STRENGTH;
        end
      end
      ST_STRENGTH: state_next = ST_WEIGHT;
      ST_WEIGHT: begin
        if (cnt_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: state_next = ST_ACCUM;
      ST_ACCUM: state_next = last ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    range_step    = 1'b0;
    strength_load = 1'b0;
    weight_step   = 1'b0;
    round_load    = 1'b0;
    accum_en      = 1'b0;
    emit_load     = 1'b0;
    case (state)
      ST_IDLE:     in_ready = 1'b1;
      ST_RANGE:    range_step = 1'b1;
      ST_STRENGTH: strength_load = 1'b1;
      ST_WEIGHT:   weight_step = 1'b1;
      ST_ROUND:    round_load = 1'b1;
      ST_ACCUM:    accum_en = 1'b1;
      ST_EMIT:     emit_load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      left_sum    <= '0;
      right_sum   <= '0;
      out_valid   <= 1'b0;
      base_speed  <= BASE_SPEED_RST;
      near_limit  <= NEAR_LIMIT_RST;
      far_limit   <= FAR_LIMIT_RST;
      range_scale <= RANGE_SCALE_RST;
    end else begin
      state <= state_next;
      cnt   <= (range_step || weight_step) && !cnt_done ? cnt + CW'(1) : '0;

      if (cfg.valid) begin
        case (cfg.index)
          CFG_BASE_SPEED:  base_speed  <= cfg.data;
          CFG_NEAR_LIMIT:  near_limit  <= cfg.data;
          CFG_FAR_LIMIT:   far_limit   <= cfg.data;
          CFG_RANGE_SCALE: range_scale <= cfg.data;
          default: begin
          end
        endcase
      end

      if (accum_en) begin
        left_sum  <= sum_sub(left_sum, left_amt);
        right_sum <= sum_sub(right_sum, right_amt);
      end else if (emit_load) begin
        left_sum  <= '0;
        right_sum <= '0;
      end

      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (wheel.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      xa         <= MW'(diff);
      pa         <= {{MW{1'b0}}, MP'(range_scale)};
      weight_sel <= sonar.sensor_index[WSEL_W-1:0];
      last       <= is_last;
      left_amt   <= '0;
      right_amt  <= '0;
    end
    if (range_step || weight_step) begin
      pa <= mul_step(pa, xa);
      pb <= mul_step(pb, xb);
    end
    if (strength_load) begin
      xa <= weight_left[weight_sel];
      xb <= weight_right[weight_sel];
      pa <= {{MW{1'b0}}, MP'(strength)};
      pb <= {{MW{1'b0}}, MP'(strength)};
    end
    if (round_load) begin
      left_amt  <= MW'(ra_shift);
      right_amt <= MW'(rb_shift);
    end
    if (emit_load) begin
      out_left  <= left_res[SPEED_W-1:0];
      out_right <= right_res[SPEED_W-1:0];
      out_sat   <= left_res[SPEED_W] || right_res[SPEED_W];
    end
  end

  assign sonar.ready           = in_ready;
  assign cfg.ready             = 1'b1;
  assign wheel.valid           = out_valid;
  assign wheel.left_speed      = out_left;
  assign wheel.right_speed     = out_right;
  assign wheel.speed_saturated = out_sat;

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result appeared outside the emit step");

  a_sums_restart: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> (left_sum == '0 && right_sum == '0))
    else $error("sums not cleared after a result");

  a_sums_not_positive: assert property (@(posedge clk) disable iff (rst)
    (left_sum[SUM_W-1] || left_sum == '0) && (right_sum[SUM_W-1] || right_sum == '0))
    else $error("a sum went positive");

  a_strength_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STRENGTH) |-> ((PW + 1)'(strength) <= ONE))
    else $error("strength above one");

endmodule

/* dv/tb.sv */
module tb;
  import bsws_pkg::*;

  localparam int FB         = FRACTION_BITS_DEF;
  localparam int LAST_SONAR = (SENSOR_COUNT_DEF - 1 > 15) ? 15 : SENSOR_COUNT_DEF - 1;
  localparam longint unsigned ONE  = 64'd1 << FB;
  localparam longint unsigned HALF = 64'd1 << (FB - 1);
  localparam longint SUM_HI   = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO   = -(64'sd1 <<< (SUM_W - 1));
  localparam longint SPEED_HI = (64'sd1 <<< (SPEED_W - 1)) - 1;
  localparam longint SPEED_LO = -(64'sd1 <<< (SPEED_W - 1));
  localparam int SETTLE     = 40;
  localparam int LONG_HOLD  = 400;
  localparam int IDLE_LIMIT = 10000;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] =
    '{CFG_BASE_SPEED, CFG_NEAR_LIMIT, CFG_FAR_LIMIT, CFG_RANGE_SCALE};

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic              echo;
    logic [DIST_W-1:0] distance;
  } sonar_rd_t;

  typedef struct {
    logic signed [SPEED_W-1:0] left;
    logic signed [SPEED_W-1:0] right;
    logic                      sat;
  } wheel_cmd_t;

  logic clk = 1'b0;
  logic rst;

  bsws_cfg_if cfg_if ();
  bsws_in_if  sonar_if ();
  bsws_out_if wheel_if ();

  braitenberg_sonar_wheel_speed_core i_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_if),
    .sonar (sonar_if),
    .wheel (wheel_if)
  );

  always #1 clk = ~clk;

  // own copy of the registers and scan sums
  logic signed [CFG_W-1:0] base_q;
  logic [CFG_W-1:0]        near_q, far_q, scale_q;
  logic signed [SUM_W-1:0] left_acc, right_acc;

  sonar_rd_t  reading_q[$];
  wheel_cmd_t wheel_due_q[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int err_cnt = 0;
  int hold_left;
  logic hold_req = 1'b0;
  int quiet_cycles;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic longint unsigned weight_of(input int tenths);
    return (longint'(tenths) * ONE + 5) / 10;
  endfunction

  // accumulate one reading; a last-index reading closes the scan
  function automatic void advance_scan(input logic [IDX_W-1:0] idx, input logic echo,
                                       input logic [DIST_W-1:0] distance);
    longint unsigned d, t, s, lc, rc;
    longint l, r, lsat, rsat;
    wheel_cmd_t cmd;
    if (idx >= SENSOR_COUNT_DEF) return;
    if (echo && distance < far_q && idx < WEIGHTED_SONARS) begin
      d = (distance < near_q) ? near_q : distance;
      t = ((d - near_q) * longint'(scale_q) + HALF) >> FB;
      if (t > ONE) t = ONE;
      s = ONE - t;
      lc = (weight_of(LEFT_TENTHS[idx]) * s + HALF) >> FB;
      rc = (weight_of(RIGHT_TENTHS[idx]) * s + HALF) >> FB;
      left_acc  = SUM_W'(clamp(longint'(left_acc) - longint'(lc), SUM_LO, SUM_HI));
      right_acc = SUM_W'(clamp(longint'(right_acc) - longint'(rc), SUM_LO, SUM_HI));
    end
    if (idx == LAST_SONAR) begin
      l = longint'(base_q) + longint'(left_acc);
      r = longint'(base_q) + longint'(right_acc);
      lsat = clamp(l, SPEED_LO, SPEED_HI);
      rsat = clamp(r, SPEED_LO, SPEED_HI);
      cmd.left  = SPEED_W'(lsat);
      cmd.right = SPEED_W'(rsat);
      cmd.sat   = (lsat != l) || (rsat != r);
      wheel_due_q.push_back(cmd);
      left_acc  = '0;
      right_acc = '0;
    end
  endfunction

  // sonar request driver
  always @(posedge clk) begin
    sonar_rd_t rd;
    if (rst) begin
      sonar_if.valid <= 1'b0;
    end else if (!sonar_if.valid || sonar_if.ready) begin
      if (reading_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        rd = reading_q.pop_front();
        sonar_if.valid        <= 1'b1;
        sonar_if.sensor_index <= rd.idx;
        sonar_if.echo_valid   <= rd.echo;
        sonar_if.distance     <= rd.distance;
      end else begin
        sonar_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_left <= LONG_HOLD;
    end
  end

  always @(posedge clk) begin
    wheel_if.ready <= !rst && hold_left == 0 && $urandom_range(99) >= rx_stall_pct;
  end

  // checker and predictor
  always @(posedge clk) begin
    wheel_cmd_t want;
    if (!rst) begin
      if (wheel_if.valid && wheel_if.ready) begin
        if (wheel_due_q.size() == 0) begin
          $error("wheel request with nothing expected: left %0d right %0d sat %0b",
                 wheel_if.left_speed, wheel_if.right_speed, wheel_if.speed_saturated);
          err_cnt++;
        end else begin
          want = wheel_due_q.pop_front();
          if (wheel_if.left_speed !== want.left) begin
            $error("left_speed: expected %0d, got %0d", want.left, wheel_if.left_speed);
            err_cnt++;
          end
          if (wheel_if.right_speed !== want.right) begin
            $error("right_speed: expected %0d, got %0d", want.right, wheel_if.right_speed);
            err_cnt++;
          end
          if (wheel_if.speed_saturated !== want.sat) begin
            $error("speed_saturated: expected %0b, got %0b", want.sat,
                   wheel_if.speed_saturated);
            err_cnt++;
          end
        end
      end
      if (sonar_if.valid && sonar_if.ready)
        advance_scan(sonar_if.sensor_index, sonar_if.echo_valid, sonar_if.distance);
    end
  end

  // watchdog on cycles with no request moving anywhere
  always @(posedge clk) begin
    if (rst || (sonar_if.valid && sonar_if.ready) || (wheel_if.valid && wheel_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_reading(input int idx, input bit echo, input int distance);
    sonar_rd_t rd;
    rd.idx      = IDX_W'(idx);
    rd.echo     = echo;
    rd.distance = DIST_W'(distance);
    reading_q.push_back(rd);
  endtask

  function automatic int pick_dist();
    int hi, v;
    hi = int'(far_q) + 64;
    if (hi > 65535) hi = 65535;
    case ($urandom_range(9))
      6: v = int'(near_q) + int'($urandom_range(2)) - 1;
      7: v = int'(far_q) - int'($urandom_range(1));
      8: v = int'($urandom_range(65535));
      9: v = $urandom_range(1) ? 65535 : 0;
      default: v = int'($urandom_range(hi));
    endcase
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  // mostly ordered scans, some stray readings
  task automatic queue_scans(input int n);
    int cnt, len;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(9) < 8) begin
        for (int i = 0; i <= LAST_SONAR; i++) begin
          if (i == LAST_SONAR || $urandom_range(9) != 0) begin
            queue_reading(i, $urandom_range(99) < 85, pick_dist());
            cnt++;
          end
        end
      end else begin
        len = $urandom_range(6, 1);
        repeat (len) begin
          queue_reading($urandom_range(15), $urandom_range(1), $urandom_range(65535));
          cnt++;
        end
      end
    end
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] bs, input logic [CFG_W-1:0] nl,
                              input logic [CFG_W-1:0] fl, input logic [CFG_W-1:0] rs);
    logic [CFG_W-1:0] vals [4];
    vals = '{bs, nl, fl, rs};
    @(posedge clk);
    for (int r = 0; r < 4; r++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= REG_ORDER[r];
      cfg_if.data  <= vals[r];
      do @(posedge clk); while (!cfg_if.ready);
      case (REG_ORDER[r])
        CFG_BASE_SPEED:  base_q  = vals[r];
        CFG_NEAR_LIMIT:  near_q  = vals[r];
        CFG_FAR_LIMIT:   far_q   = vals[r];
        CFG_RANGE_SCALE: scale_q = vals[r];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic program_random_regs();
    int nl, fl, span, rs;
    nl = $urandom_range(6000);
    fl = ($urandom_range(9) == 0) ? $urandom_range(nl) : nl + $urandom_range(8000, 1);
    if (fl > 65535) fl = 65535;
    span = fl - nl;
    if (span <= 0 || $urandom_range(3) == 0)
      rs = $urandom_range(65535);
    else
      rs = ((1 << (2 * FB)) + span / 2) / span;
    if (rs > 65535) rs = 65535;
    program_regs(CFG_W'($urandom_range(65535)), CFG_W'(nl), CFG_W'(fl), CFG_W'(rs));
  endtask

  task automatic set_idling(input int tx, input int rx);
    @(negedge clk);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
  endtask

  // everything sent and answered, then let a silent reading finish
  task automatic wait_drained();
    do @(negedge clk);
    while (reading_q.size() != 0 || sonar_if.valid || wheel_due_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_BASE_SPEED;
    cfg_if.data = '0;
    sonar_if.valid = 1'b0;
    sonar_if.sensor_index = '0;
    sonar_if.echo_valid = 1'b0;
    sonar_if.distance = '0;
    wheel_if.ready = 1'b0;
    base_q = BASE_SPEED_RST;
    near_q = NEAR_LIMIT_RST;
    far_q = FAR_LIMIT_RST;
    scale_q = RANGE_SCALE_RST;
    left_acc = '0;
    right_acc = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset registers, limits and every weighted sonar
    program_regs(BASE_SPEED_RST, NEAR_LIMIT_RST, FAR_LIMIT_RST, RANGE_SCALE_RST);
    set_idling(0, 0);
    queue_reading(0, 1, 0);
    queue_reading(1, 1, NEAR_LIMIT_RST);
    queue_reading(2, 1, 1000);
    queue_reading(3, 1, FAR_LIMIT_RST - 1);
    queue_reading(4, 1, FAR_LIMIT_RST);
    queue_reading(5, 1, 65535);
    queue_reading(6, 0, 0);
    queue_reading(7, 1, 1500);
    queue_reading(8, 1, 0);
    queue_reading(12, 1, 0);
    queue_reading(LAST_SONAR, 1, 0);
    // empty scan
    queue_reading(LAST_SONAR, 0, 65535);
    for (int i = 0; i < WEIGHTED_SONARS; i++) queue_reading(i, 1, 0);
    queue_reading(LAST_SONAR, 1, 100);
    // repeated sonar in one scan
    queue_reading(3, 1, 500);
    queue_reading(3, 1, 500);
    queue_reading(LAST_SONAR, 0, 0);
    wait_drained();

    program_random_regs();
    set_idling(0, 0);
    queue_scans(100);
    wait_drained();

    program_random_regs();
    set_idling(84, 0);
    queue_scans(80);
    wait_drained();

    // receiver holds off while readings keep coming, then the sender waits it out
    program_random_regs();
    set_idling(0, 84);
    hold_req = 1'b1;
    queue_scans(40);
    do @(negedge clk); while (hold_left == 0);
    hold_req = 1'b0;
    wait_drained();
    @(negedge clk);
    queue_scans(40);
    wait_drained();

    program_random_regs();
    set_idling(17, 17);
    queue_scans(100);
    wait_drained();

    // near limit not below far limit, most negative base, largest scale
    program_regs(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_idling(17, 17);
    queue_scans(50);
    wait_drained();

    // far limit zero: nothing seen, fastest base
    program_regs(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    set_idling(0, 0);
    queue_scans(50);
    wait_drained();

    // one long scan that drives both wheel speeds into clipping
    program_regs(16'h8000, NEAR_LIMIT_RST, FAR_LIMIT_RST, RANGE_SCALE_RST);
    set_idling(0, 0);
    for (int i = 0; i < 80; i++) begin
      queue_reading(0, 1, 0);
      queue_reading(7, 1, 0);
    end
    queue_reading(LAST_SONAR, 1, 0);
    wait_drained();

    if (err_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* braitenberg_sonar_wheel_speed_core.f */
hdl/bsws_pkg.sv
hdl/bsws_ifs.sv
hdl/braitenberg_sonar_wheel_speed_core.sv
dv/tb.sv
